/* sv/lru_hit_count_promotion_filter_macros.svh */
// Assertion helpers for the LRU hit-count filter.
`ifndef LRU_HIT_COUNT_PROMOTION_FILTER_MACROS_SVH
`define LRU_HIT_COUNT_PROMOTION_FILTER_MACROS_SVH
// Concurrent check that is disabled while reset is low.
`define LHF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent check that also holds during reset.
`define LHF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* sv/lhf_pkg.sv */
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared types and constants of the LRU hit-count filter.
// ----------------------------------------------------------------------------
`default_nettype none
package lhf_pkg;
  localparam int HIT_W  = 16;
  localparam int BYTE_W = 48;
  localparam int CNT_W  = 7;
  localparam logic [HIT_W-1:0]  HITS_MAX  = '1;
  localparam logic [BYTE_W-1:0] BYTES_MAX = '1;
  localparam int MIN_BUCKETS = 10;

  localparam logic OP_REQ = 1'b0;
  localparam logic OP_ADD = 1'b1;

  localparam logic [1:0] CFG_HIT_THR  = 2'd0;
  localparam logic [1:0] CFG_BYTE_THR = 2'd1;
  localparam logic [1:0] CFG_BUCKETS  = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_DEC   = 7'b0000100,
    ST_AGE   = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_WAIT  = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

/* sv/lhf_ram.sv */
// ----------------------------------------------------------------------------
// lhf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lhf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/lru_hit_count_promotion_filter.sv */
// LRU hit-count promotion filter. A request passes through these steps from the
// accepting edge to the next one: the idle step, a pass over the entry memory
// that finds the key, the least recent entry and the first free slot, a decision
// step, a second pass that rewrites the age ranks of the valid entries other
// than the target as the decided mode asks, a write-back step and an output
// step. An add-bytes item takes an extra wait step. The single memory read
// port sets the pace: one entry per cycle in each pass. The result is
// registered. Entry payload (key, hits, bytes, rank) sits in one RAM; valid
// bits are flip-flops cleared by reset, so no clearing pass is needed. A new
// request is taken as soon as the sequencer is idle; a result still held in
// the output register only holds the next request at its output step.
// ----------------------------------------------------------------------------
// lru_hit_count_promotion_filter
// Top level: handshake, configuration registers and the scan sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_hit_count_promotion_filter #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [63:0] in_key,
  input  wire logic        in_cacheable,
  input  wire logic [47:0] in_byte_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic             out_promoted,
  output logic             out_vacated,
  output logic [6:0]       out_occupancy,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  import lhf_pkg::*;
  `include "lru_hit_count_promotion_filter_macros.svh"

  localparam int AW = $clog2(ENTRIES);
  localparam int RW = AW;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int DW = KEY_BITS + HIT_W + BYTE_W + RW;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  // age-walk modes
  localparam logic [1:0] AM_NONE  = 2'd0;  // leave ranks alone
  localparam logic [1:0] AM_TOUCH = 2'd1;  // ranks below ref age by one
  localparam logic [1:0] AM_CLOSE = 2'd2;  // ranks above ref move up by one
  localparam logic [1:0] AM_ALL   = 2'd3;  // every rank ages by one

  // configuration
  logic [HIT_W-1:0]  hit_thr_r;
  logic [BYTE_W-1:0] byte_thr_r;
  logic [CNT_W-1:0]  buckets_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_thr_r  <= 16'd10;
      byte_thr_r <= '0;
      buckets_r  <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HIT_THR:  hit_thr_r  <= cfg_data[HIT_W-1:0];
        CFG_BYTE_THR: byte_thr_r <= cfg_data;
        CFG_BUCKETS:  buckets_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // bucket limit clamped into [MIN_BUCKETS, ENTRIES]
  logic [UW-1:0] limit;
  always_comb begin
    priority if (buckets_r < CNT_W'(MIN_BUCKETS)) limit = UW'(MIN_BUCKETS);
    else if ({{UW{1'b0}}, buckets_r} > (UW+CNT_W)'(ENTRIES)) limit = UW'(ENTRIES);
    else limit = UW'(buckets_r);
  end

  // entry memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  lhf_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  logic [KEY_BITS-1:0] rd_key;
  logic [HIT_W-1:0]    rd_hits;
  logic [BYTE_W-1:0]   rd_bytes;
  logic [RW-1:0]       rd_rank;
  assign {rd_key, rd_hits, rd_bytes, rd_rank} = rdata;

  logic [ENTRIES-1:0] valid_r;
  logic [UW-1:0]      used_r;
  state_t             st_r;

  // request registers
  logic                op_r, cach_r;
  logic [KEY_BITS-1:0] key_r;
  logic [BYTE_W-1:0]   add_r;

  // scan state
  logic [AW-1:0] idx_r;      // address issued last cycle
  logic          rd_ok_r;    // rdata holds entry idx_r
  logic          found_r;
  logic [AW-1:0] fslot_r;
  logic [HIT_W-1:0]  fhits_r;
  logic [BYTE_W-1:0] fbytes_r;
  logic [RW-1:0]     frank_r;
  logic          lru_ok_r;
  logic [AW-1:0] lru_slot_r;
  logic [RW-1:0] lru_rank_r;
  logic          free_ok_r;
  logic [AW-1:0] free_slot_r;

  // decision registers
  logic          hit_r, prom_r, vac_r;
  logic [1:0]    amode_r;
  logic [RW-1:0] ref_r;
  logic          tgt_ok_r;
  logic [AW-1:0] tgt_r;
  logic [HIT_W-1:0]  nhits_r;
  logic [BYTE_W-1:0] nbytes_r;
  logic [KEY_BITS-1:0] nkey_r;

  logic cur_v;
  assign cur_v = valid_r[idx_r];

  assign in_stall = (st_r != ST_IDLE);

  always_comb begin
    raddr = idx_r;
    we    = 1'b0;
    waddr = idx_r;
    wdata = rdata;
    if (st_r == ST_IDLE) raddr = '0;
    else if ((st_r == ST_SCAN || st_r == ST_AGE) && idx_r != LAST) raddr = idx_r + 1'b1;
    else if (st_r == ST_DEC) raddr = '0;
    if (st_r == ST_AGE && rd_ok_r && cur_v && !(tgt_ok_r && idx_r == tgt_r)) begin
      we = 1'b1;
      unique case (amode_r)
        AM_TOUCH: wdata = {rd_key, rd_hits, rd_bytes,
                           (rd_rank < ref_r) ? rd_rank + 1'b1 : rd_rank};
        AM_CLOSE: wdata = {rd_key, rd_hits, rd_bytes,
                           (rd_rank > ref_r) ? rd_rank - 1'b1 : rd_rank};
        AM_ALL:   wdata = {rd_key, rd_hits, rd_bytes, rd_rank + 1'b1};
        default: we = 1'b0;
      endcase
    end else if (st_r == ST_WRITE) begin
      we    = tgt_ok_r;
      waddr = tgt_r;
      // add-bytes keeps the entry rank, everything else lands at the front
      wdata = {nkey_r, nhits_r, nbytes_r, (op_r == OP_ADD) ? ref_r : RW'(0)};
    end
  end

  logic [HIT_W-1:0]  inc_hits;
  logic [BYTE_W:0]   sum_bytes;
  assign inc_hits  = (fhits_r == HITS_MAX) ? fhits_r : fhits_r + 1'b1;
  assign sum_bytes = {1'b0, fbytes_r} + {1'b0, add_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      valid_r   <= '0;
      used_r    <= '0;
      out_valid <= 1'b0;
      rd_ok_r   <= 1'b0;
      idx_r     <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: if (in_valid) begin
          // capture request, start scan at entry 0
          op_r <= in_op; cach_r <= in_cacheable;
          key_r <= in_key[KEY_BITS-1:0]; add_r <= in_byte_count;
          found_r <= 1'b0; lru_ok_r <= 1'b0; free_ok_r <= 1'b0;
          idx_r <= '0; rd_ok_r <= 1'b1;
          st_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cur_v) begin
            if (!found_r && rd_key == key_r) begin
              found_r <= 1'b1; fslot_r <= idx_r;
              fhits_r <= rd_hits; fbytes_r <= rd_bytes; frank_r <= rd_rank;
            end
            if (!lru_ok_r || rd_rank > lru_rank_r) begin
              lru_ok_r <= 1'b1; lru_slot_r <= idx_r; lru_rank_r <= rd_rank;
            end
          end else if (!free_ok_r) begin
            free_ok_r <= 1'b1; free_slot_r <= idx_r;
          end
          if (idx_r == LAST) st_r <= ST_DEC;
          else idx_r <= idx_r + 1'b1;
        end
        ST_DEC: begin
          hit_r <= found_r; prom_r <= 1'b0; vac_r <= 1'b0;
          amode_r <= AM_NONE; tgt_ok_r <= 1'b0; tgt_r <= fslot_r;
          nkey_r <= key_r; nhits_r <= inc_hits; nbytes_r <= fbytes_r; ref_r <= frank_r;
          if (op_r == OP_ADD) begin
            if (found_r) begin
              tgt_ok_r <= 1'b1;
              nhits_r  <= fhits_r;
              nbytes_r <= sum_bytes[BYTE_W] ? BYTES_MAX : sum_bytes[BYTE_W-1:0];
              amode_r  <= AM_NONE;
            end
          end else if (found_r) begin
            if (cach_r && (inc_hits >= hit_thr_r ||
                (byte_thr_r != '0 && fbytes_r > byte_thr_r))) begin
              prom_r <= 1'b1; amode_r <= AM_CLOSE;
              valid_r[fslot_r] <= 1'b0;
              if (used_r != '0) used_r <= used_r - 1'b1;
            end else begin
              tgt_ok_r <= 1'b1; amode_r <= AM_TOUCH;
            end
          end else if (used_r >= limit && used_r != '0 && lru_ok_r) begin
            vac_r <= 1'b1; tgt_ok_r <= 1'b1; tgt_r <= lru_slot_r;
            ref_r <= lru_rank_r; amode_r <= AM_TOUCH;
            nhits_r <= HIT_W'(1); nbytes_r <= '0;
          end else if (free_ok_r) begin
            tgt_ok_r <= 1'b1; tgt_r <= free_slot_r; amode_r <= AM_ALL;
            nhits_r <= HIT_W'(1); nbytes_r <= '0;
            valid_r[free_slot_r] <= 1'b1;
            used_r <= used_r + 1'b1;
          end
          idx_r <= '0;
          st_r  <= ST_AGE;
        end
        ST_AGE: begin
          // walk ranks; the target's own row is rewritten afterwards
          if (idx_r == LAST) st_r <= ST_WRITE;
          else idx_r <= idx_r + 1'b1;
        end
        ST_WRITE: begin
          if (op_r == OP_ADD) st_r <= ST_WAIT;
          else st_r <= ST_OUT;
        end
        ST_WAIT: st_r <= ST_OUT;
        ST_OUT: if (!out_valid || !out_stall) begin
          out_valid     <= 1'b1;
          out_hit       <= hit_r;
          out_promoted  <= prom_r;
          out_vacated   <= vac_r;
          out_occupancy <= 7'(used_r);
          st_r          <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
      if (out_valid && !out_stall && st_r != ST_OUT) out_valid <= 1'b0;
    end
  end

  `LHF_ASSERT(a_busy_stall, (st_r != ST_IDLE) |-> in_stall, "busy without stall")
  `LHF_ASSERT(a_occ_bound, used_r <= UW'(ENTRIES), "occupancy above table size")
  `LHF_ASSERT(a_prom_hit, out_valid && out_promoted |-> out_hit && !out_vacated,
    "promotion without hit")
  `LHF_ASSERT(a_vac_miss, out_valid && out_vacated |-> !out_hit, "vacate on a hit")
endmodule
`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU hit-count promotion filter. A driver feeds
// requests from a pending queue and predicts each result when the request is
// taken. A monitor compares every result with the oldest prediction. The run
// steps through several threshold and bucket settings, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import lhf_pkg::*;

  localparam int SLOTS     = 64;
  localparam int MAX_CYCLE = 3000000;

  typedef struct packed {
    logic              op;
    logic [63:0]       key;
    logic              cacheable;
    logic [BYTE_W-1:0] nbytes;
  } request_t;

  typedef struct packed {
    logic             hit;
    logic             promoted;
    logic             vacated;
    logic [CNT_W-1:0] occupancy;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_REQ;
  logic [63:0]       in_key = '0;
  logic              in_cacheable = 1'b0;
  logic [47:0]       in_byte_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic              out_promoted;
  logic              out_vacated;
  logic [6:0]        out_occupancy;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_HIT_THR;
  logic [47:0]       cfg_data = '0;

  lru_hit_count_promotion_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_key(in_key),
    .in_cacheable(in_cacheable), .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_promoted(out_promoted), .out_vacated(out_vacated),
    .out_occupancy(out_occupancy),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the filter table and its settings.
  logic [63:0]       tbl_key   [SLOTS];
  logic [HIT_W-1:0]  tbl_hits  [SLOTS];
  logic [BYTE_W-1:0] tbl_bytes [SLOTS];
  bit                tbl_live  [SLOTS];
  int                tbl_rank  [SLOTS];
  int                tbl_held = 0;
  logic [HIT_W-1:0]  thr_hits = 16'd10;
  logic [BYTE_W-1:0] thr_bytes = '0;
  logic [6:0]        buckets = 7'd64;

  request_t pending_reqs [$];
  verdict_t expected_verdicts [$];

  int issued = 0, received = 0, mismatches = 0, cycles = 0;
  int n_hit = 0, n_promo = 0, n_vac = 0;
  bit quiet = 0;

  // Move slot s to the front; younger entries age by one.
  function automatic void make_recent(int s);
    int r;
    r = tbl_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (tbl_live[i] && i != s && tbl_rank[i] < r) tbl_rank[i]++;
    tbl_rank[s] = 0;
  endfunction

  function automatic verdict_t filter_step(request_t rq);
    verdict_t v;
    int s, slot, limit, best, r;
    logic [BYTE_W:0] sum;
    v = '0;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && tbl_live[i] && tbl_key[i] == rq.key) s = i;
    v.hit = (s >= 0);
    if (rq.op == OP_ADD) begin
      if (s >= 0) begin
        sum = {1'b0, tbl_bytes[s]} + {1'b0, rq.nbytes};
        tbl_bytes[s] = sum[BYTE_W] ? BYTES_MAX : sum[BYTE_W-1:0];
      end
    end else if (s >= 0) begin
      if (tbl_hits[s] != HITS_MAX) tbl_hits[s]++;
      if (rq.cacheable && (tbl_hits[s] >= thr_hits ||
          (thr_bytes != 0 && tbl_bytes[s] > thr_bytes))) begin
        r = tbl_rank[s];
        tbl_live[s] = 0;
        for (int i = 0; i < SLOTS; i++)
          if (tbl_live[i] && tbl_rank[i] > r) tbl_rank[i]--;
        if (tbl_held > 0) tbl_held--;
        v.promoted = 1;
      end else begin
        make_recent(s);
      end
    end else begin
      limit = buckets < MIN_BUCKETS ? MIN_BUCKETS : (buckets > SLOTS ? SLOTS : buckets);
      slot = -1;
      best = 0;
      if (tbl_held >= limit && tbl_held > 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_live[i] && (slot < 0 || tbl_rank[i] > best)) begin
            slot = i;
            best = tbl_rank[i];
          end
        if (slot >= 0) begin
          make_recent(slot);
          v.vacated = 1;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && !tbl_live[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (tbl_live[i]) tbl_rank[i]++;
          tbl_live[slot] = 1;
          tbl_rank[slot] = 0;
          tbl_held++;
        end
      end
      if (slot >= 0) begin
        tbl_key[slot] = rq.key;
        tbl_hits[slot] = 1;
        tbl_bytes[slot] = '0;
      end
    end
    v.occupancy = tbl_held[6:0];
    return v;
  endfunction

  // Driver: present pending requests, predict each one as it is taken.
  int in_gap = 0;
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        expected_verdicts.push_back(filter_step({in_op, in_key, in_cacheable, in_byte_count}));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          // hold off the input for a random gap
          in_valid <= 1'b0;
          in_gap = $urandom_range(0, 4);
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_valid      <= 1'b1;
          in_op         <= nxt.op;
          in_key        <= nxt.key;
          in_cacheable  <= nxt.cacheable;
          in_byte_count <= nxt.nbytes;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest prediction.
  int out_gap = 0;
  always @(posedge clk) begin
    verdict_t want, got;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_hit, out_promoted, out_vacated, out_occupancy};
        received++;
        n_hit += out_hit;
        n_promo += out_promoted;
        n_vac += out_vacated;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected hit=%b promoted=%b vacated=%b occ=%0d",
                received, want.hit, want.promoted, want.vacated, want.occupancy);
              $display("  got hit=%b promoted=%b vacated=%b occ=%0d",
                got.hit, got.promoted, got.vacated, got.occupancy);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        out_gap = $urandom_range(0, 4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic add_request(logic op, logic [63:0] key, logic cacheable, logic [47:0] nb);
    pending_reqs.push_back({op, key, cacheable, nb});
    issued++;
  endtask

  // Wait until every request has produced its result.
  task automatic drain();
    while (received != issued || pending_reqs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HIT_THR:  thr_hits = val[HIT_W-1:0];
      CFG_BYTE_THR: thr_bytes = val;
      CFG_BUCKETS:  buckets = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [15:0] h, logic [47:0] b, logic [6:0] bk);
    drain();
    write_reg(CFG_HIT_THR, {32'd0, h});
    write_reg(CFG_BYTE_THR, b);
    write_reg(CFG_BUCKETS, {41'd0, bk});
  endtask

  // Random traffic over a pool of recurring keys, with some fresh ones.
  task automatic random_phase(int count, int pool_n, int add_max);
    logic [63:0] pool [$];
    logic [63:0] k;
    logic [47:0] nb;
    for (int i = 0; i < pool_n; i++) pool.push_back({$urandom, $urandom});
    for (int i = 0; i < count; i++) begin
      k  = ($urandom_range(0, 99) < 8) ? {$urandom, $urandom}
                                        : pool[$urandom_range(0, pool_n - 1)];
      nb = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                        : 48'($urandom_range(0, add_max));
      add_request(($urandom_range(0, 99) < 15) ? OP_ADD : OP_REQ, k,
                  $urandom_range(0, 9) < 7, nb);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: misses, absent add, byte saturation, non-cacheable hit.
    add_request(OP_REQ, 64'd0, 1'b1, '0);
    add_request(OP_REQ, '1, 1'b1, '1);
    add_request(OP_ADD, 64'd5, 1'b1, 48'd100);
    add_request(OP_ADD, 64'd0, 1'b0, BYTES_MAX);
    add_request(OP_ADD, 64'd0, 1'b1, BYTES_MAX);
    add_request(OP_REQ, 64'd0, 1'b0, '0);
    add_request(OP_REQ, 64'd0, 1'b1, '0);
    // Zero hit threshold promotes any cacheable hit; byte threshold kicks in.
    apply_settings(16'd0, 48'd1, 7'd64);
    add_request(OP_REQ, 64'd0, 1'b1, '0);
    add_request(OP_REQ, '1, 1'b0, '0);
    add_request(OP_ADD, '1, 1'b0, 48'd2);
    apply_settings(16'hFFFF, 48'd1, 7'd64);
    add_request(OP_REQ, '1, 1'b1, '0);
    add_request(OP_REQ, 64'h8000_0000_0000_0001, 1'b1, '0);

    apply_settings(16'd2, 48'd0, 7'd10);
    random_phase(200, 16, 3000);
    apply_settings(16'd5, 48'd1000, 7'd0);
    random_phase(250, 30, 900);
    apply_settings(16'd0, BYTES_MAX, 7'd127);
    random_phase(200, 80, 3000);
    apply_settings(16'hFFFF, 48'd5000000, 7'd64);
    random_phase(250, 70, 2000000);
    apply_settings(16'd3, 48'd0, 7'd40);
    random_phase(300, 50, 3000);
    // Shrink the bucket limit below what the table holds now.
    apply_settings(16'd4, 48'd0, 7'd12);
    random_phase(250, 40, 3000);
    apply_settings(16'd10, 48'd0, 7'd64);
    drain();
    quiet = 1;
    random_phase(200, 60, 3000);
    drain();
    repeat (20) @(posedge clk);

    if (expected_verdicts.size() != 0) mismatches += expected_verdicts.size();
    $display("%0d requests checked over 10 settings: %0d hits, %0d promotions, %0d replacements",
      received, n_hit, n_promo, n_vac);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
